### src/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants for the JSON string unescaper
// Phase and status codes, decoder state, one item's result run, and the
// character codes tested by the decoder.
// ----------------------------------------------------------------------------
package jsu_pkg;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_STR     = 4'd1,
        PH_ESC     = 4'd2,
        PH_HEX1    = 4'd3,
        PH_WANT_BS = 4'd4,
        PH_WANT_U  = 4'd5,
        PH_HEX2    = 4'd6
    } t_phase;

    typedef enum logic [3:0] {
        ST_OK       = 4'd0,
        ST_NOQUOTE  = 4'd1,
        ST_UNTERM   = 4'd2,
        ST_TRUNC    = 4'd3,
        ST_NONHEX   = 4'd4,
        ST_LONEHIGH = 4'd5,
        ST_BADLOW   = 4'd6,
        ST_LONELOW  = 4'd7,
        ST_BADESC   = 4'd8,
        ST_CTRL     = 4'd9
    } t_status;

    typedef struct packed {
        t_phase      phase;
        logic [15:0] hex_accum;
        logic [2:0]  digit_count;
        logic        bad_digit_seen;
        logic [9:0]  high_half;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:          PH_IDLE,
        hex_accum:      16'h0000,
        digit_count:    3'd0,
        bad_digit_seen: 1'b0,
        high_half:      10'd0
    };

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      nbytes;
        logic            term;
        t_status         status;
    } t_run;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;

    localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;

    // 0..15 for a hex digit, bit 4 set otherwise
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] d;
        d = 5'h10;
        if (b inside {[8'h30:8'h39]}) begin
            d = {1'b0, b[3:0]};
        end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            d = {1'b0, b[3:0] + 4'd9};
        end
        return d;
    endfunction

endpackage

### src/jsu_decode.sv
// ----------------------------------------------------------------------------
// jsu_decode: per-item decode step
// From the current phase and one input byte, form the next decoder state and
// the run of results (up to four UTF-8 bytes and a terminal status).
// ----------------------------------------------------------------------------
module jsu_decode (
    input  jsu_pkg::t_state i_state,
    input  logic [7:0]      i_in_byte,
    input  logic            i_final_byte,
    output jsu_pkg::t_state o_state,
    output jsu_pkg::t_run   o_run
);

    logic [4:0]       dig;
    logic [15:0]      acc_n;
    logic [2:0]       cnt_n;
    logic             bad_n;
    logic [20:0]      cp;
    logic [3:0][7:0]  enc_bytes;
    logic [2:0]       enc_n;
    logic             fin_req;
    jsu_pkg::t_status fin_st;

    assign dig   = jsu_pkg::hex_value(i_in_byte);
    assign acc_n = {i_state.hex_accum[11:0], dig[3:0]};
    assign cnt_n = i_state.digit_count + 3'd1;
    assign bad_n = i_state.bad_digit_seen | dig[4];

    assign cp = (i_state.phase == jsu_pkg::PH_HEX2)
              ? 21'h10000 + {1'b0, i_state.high_half, acc_n[9:0]}
              : {5'd0, acc_n};

    always_comb begin
        enc_bytes = '0;
        if (cp < 21'h80) begin
            enc_n        = 3'd1;
            enc_bytes[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            enc_n        = 3'd2;
            enc_bytes[0] = {3'b110, cp[10:6]};
            enc_bytes[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            enc_n        = 3'd3;
            enc_bytes[0] = {4'b1110, cp[15:12]};
            enc_bytes[1] = {2'b10, cp[11:6]};
            enc_bytes[2] = {2'b10, cp[5:0]};
        end else begin
            enc_n        = 3'd4;
            enc_bytes[0] = {5'b11110, cp[20:18]};
            enc_bytes[1] = {2'b10, cp[17:12]};
            enc_bytes[2] = {2'b10, cp[11:6]};
            enc_bytes[3] = {2'b10, cp[5:0]};
        end
    end

    always_comb begin
        o_state = i_state;
        o_run   = '0;
        fin_req = 1'b0;
        fin_st  = jsu_pkg::ST_OK;
        case (i_state.phase)
            jsu_pkg::PH_IDLE: begin
                if (i_in_byte inside {jsu_pkg::CH_SPACE, jsu_pkg::CH_TAB,
                                      jsu_pkg::CH_LF, jsu_pkg::CH_CR}) begin
                    fin_req = i_final_byte;
                    fin_st  = jsu_pkg::ST_NOQUOTE;
                end else if (i_in_byte == jsu_pkg::CH_QUOTE) begin
                    o_state       = jsu_pkg::STATE_RESET;
                    o_state.phase = jsu_pkg::PH_STR;
                    fin_req       = i_final_byte;
                    fin_st        = jsu_pkg::ST_UNTERM;
                end else begin
                    fin_req = 1'b1;
                    fin_st  = jsu_pkg::ST_NOQUOTE;
                end
            end
            jsu_pkg::PH_STR: begin
                if (i_in_byte == jsu_pkg::CH_QUOTE) begin
                    fin_req = 1'b1;
                    fin_st  = jsu_pkg::ST_OK;
                end else if (i_in_byte == jsu_pkg::CH_BSLASH) begin
                    o_state.phase = jsu_pkg::PH_ESC;
                    fin_req       = i_final_byte;
                    fin_st        = jsu_pkg::ST_UNTERM;
                end else if (i_in_byte < jsu_pkg::CH_SPACE) begin
                    fin_req = 1'b1;
                    fin_st  = jsu_pkg::ST_CTRL;
                end else begin
                    o_run.bytes[0] = i_in_byte;
                    o_run.nbytes   = 3'd1;
                    fin_req        = i_final_byte;
                    fin_st         = jsu_pkg::ST_UNTERM;
                end
            end
            jsu_pkg::PH_ESC: begin
                fin_req       = i_final_byte;
                fin_st        = jsu_pkg::ST_UNTERM;
                o_run.nbytes  = 3'd1;
                o_state.phase = jsu_pkg::PH_STR;
                case (i_in_byte)
                    jsu_pkg::CH_QUOTE:  o_run.bytes[0] = jsu_pkg::CH_QUOTE;
                    jsu_pkg::CH_BSLASH: o_run.bytes[0] = jsu_pkg::CH_BSLASH;
                    jsu_pkg::CH_SLASH:  o_run.bytes[0] = jsu_pkg::CH_SLASH;
                    jsu_pkg::CH_LOW_B:  o_run.bytes[0] = jsu_pkg::CH_BS;
                    jsu_pkg::CH_LOW_F:  o_run.bytes[0] = jsu_pkg::CH_FF;
                    jsu_pkg::CH_LOW_N:  o_run.bytes[0] = jsu_pkg::CH_LF;
                    jsu_pkg::CH_LOW_R:  o_run.bytes[0] = jsu_pkg::CH_CR;
                    jsu_pkg::CH_LOW_T:  o_run.bytes[0] = jsu_pkg::CH_TAB;
                    jsu_pkg::CH_LOW_U: begin
                        o_run.nbytes           = 3'd0;
                        o_state.phase          = jsu_pkg::PH_HEX1;
                        o_state.hex_accum      = 16'h0000;
                        o_state.digit_count    = 3'd0;
                        o_state.bad_digit_seen = 1'b0;
                        fin_st                 = jsu_pkg::ST_TRUNC;
                    end
                    default: begin
                        o_run.nbytes = 3'd0;
                        fin_req      = 1'b1;
                        fin_st       = jsu_pkg::ST_BADESC;
                    end
                endcase
            end
            jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
                o_state.hex_accum      = acc_n;
                o_state.digit_count    = cnt_n;
                o_state.bad_digit_seen = bad_n;
                if (!cnt_n[2]) begin
                    fin_req = i_final_byte;
                    fin_st  = jsu_pkg::ST_TRUNC;
                end else if (bad_n) begin
                    fin_req = 1'b1;
                    fin_st  = jsu_pkg::ST_NONHEX;
                end else if (i_state.phase == jsu_pkg::PH_HEX1) begin
                    if (acc_n[15:10] == jsu_pkg::SURR_HIGH_TAG) begin
                        o_state.high_half = acc_n[9:0];
                        o_state.phase     = jsu_pkg::PH_WANT_BS;
                        fin_req           = i_final_byte;
                        fin_st            = jsu_pkg::ST_LONEHIGH;
                    end else if (acc_n[15:10] == jsu_pkg::SURR_LOW_TAG) begin
                        fin_req = 1'b1;
                        fin_st  = jsu_pkg::ST_LONELOW;
                    end else begin
                        o_run.bytes   = enc_bytes;
                        o_run.nbytes  = enc_n;
                        o_state.phase = jsu_pkg::PH_STR;
                        fin_req       = i_final_byte;
                        fin_st        = jsu_pkg::ST_UNTERM;
                    end
                end else begin
                    if (acc_n[15:10] != jsu_pkg::SURR_LOW_TAG) begin
                        fin_req = 1'b1;
                        fin_st  = jsu_pkg::ST_BADLOW;
                    end else begin
                        o_run.bytes   = enc_bytes;
                        o_run.nbytes  = enc_n;
                        o_state.phase = jsu_pkg::PH_STR;
                        fin_req       = i_final_byte;
                        fin_st        = jsu_pkg::ST_UNTERM;
                    end
                end
            end
            jsu_pkg::PH_WANT_BS: begin
                if (i_in_byte != jsu_pkg::CH_BSLASH || i_final_byte) begin
                    fin_req = 1'b1;
                    fin_st  = jsu_pkg::ST_LONEHIGH;
                end else begin
                    o_state.phase = jsu_pkg::PH_WANT_U;
                end
            end
            jsu_pkg::PH_WANT_U: begin
                if (i_in_byte != jsu_pkg::CH_LOW_U) begin
                    fin_req = 1'b1;
                    fin_st  = jsu_pkg::ST_LONEHIGH;
                end else begin
                    o_state.phase          = jsu_pkg::PH_HEX2;
                    o_state.hex_accum      = 16'h0000;
                    o_state.digit_count    = 3'd0;
                    o_state.bad_digit_seen = 1'b0;
                    fin_req                = i_final_byte;
                    fin_st                 = jsu_pkg::ST_TRUNC;
                end
            end
            default: begin
                o_state = jsu_pkg::STATE_RESET;
            end
        endcase
        if (fin_req) begin
            o_state      = jsu_pkg::STATE_RESET;
            o_run.term   = 1'b1;
            o_run.status = fin_st;
        end
    end

endmodule

### src/jsu_emit.sv
// ----------------------------------------------------------------------------
// jsu_emit: result register and serializer
// Hold one item's run of results and hand them out one per cycle while
// i_out_ready is high, bytes first and the terminal status last.
// ----------------------------------------------------------------------------
module jsu_emit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  jsu_pkg::t_run i_run,
    output logic          o_free,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [7:0]    o_out_byte,
    output logic          o_byte_valid,
    output logic          o_token_done,
    output logic [3:0]    o_status,
    output logic          o_last_of_run
);

    logic          r_valid;
    jsu_pkg::t_run r_run;
    logic [2:0]    r_idx;
    logic [2:0]    total;
    logic          is_byte;
    logic          last;
    logic          take;

    assign total   = r_run.nbytes + {2'b00, r_run.term};
    assign is_byte = r_idx < r_run.nbytes;
    assign last    = (r_idx + 3'd1) == total;
    assign take    = r_valid && i_out_ready;
    assign o_free  = !r_valid || (take && last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= 3'd0;
        end else if (take) begin
            if (last) begin
                r_valid <= 1'b0;
            end
            r_idx <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_run <= i_run;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_out_byte    = is_byte ? r_run.bytes[r_idx[1:0]] : 8'h00;
    assign o_byte_valid  = is_byte;
    assign o_token_done  = !is_byte;
    assign o_status      = is_byte ? jsu_pkg::ST_OK : r_run.status;
    assign o_last_of_run = last;

endmodule

### src/json_string_unescape_utf8.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8: streaming unescaper for one JSON string token
// The first result of an item is offered in the cycle after the item is taken.
// Throughput: one item per cycle while the result register is free; an item
// with k results (k up to 5) holds that register until the single-result output
// port has handed out its last result. Reset: synchronous, active low; returns
// the decoder to idle and empties the result register.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_final_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_token_done,
    output logic [3:0] o_status,
    output logic       o_last_of_run
);

    jsu_pkg::t_state r_state;
    jsu_pkg::t_state n_state;
    jsu_pkg::t_run   run;
    logic            accept;
    logic            load;
    logic            free;

    jsu_decode u_decode (
        .i_state      (r_state),
        .i_in_byte    (i_in_byte),
        .i_final_byte (i_final_byte),
        .o_state      (n_state),
        .o_run        (run)
    );

    assign o_in_ready = free;
    assign accept     = i_in_valid && free;
    assign load       = accept && (run.nbytes != 3'd0 || run.term);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jsu_pkg::STATE_RESET;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    jsu_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load),
        .i_run         (run),
        .o_free        (free),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_token_done  (o_token_done),
        .o_status      (o_status),
        .o_last_of_run (o_last_of_run)
    );

    a_term_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_token_done |-> o_last_of_run)
        else $error("terminal result not last of its run");

    a_no_take_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_of_run |-> !o_in_ready)
        else $error("input taken while a run is still pending");

    a_byte_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_valid |-> o_status == jsu_pkg::ST_OK && !o_token_done)
        else $error("byte result carries a status");

    a_idle_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && run.term |=> r_state.phase == jsu_pkg::PH_IDLE)
        else $error("decoder not idle after token end");

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for json_string_unescape_utf8
// Feeds JSON string tokens one byte per item, first from a short table of
// hand-picked bytes and then from randomly built tokens (mostly well formed,
// some corrupted or cut short). A byte-by-byte model of the unescaper
// expects every output item, and each one is compared field by field.
// Both handshakes idle at random.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RANDOM_ITEMS = 360;
    localparam int          DRAIN_CYCLES = 20;
    localparam logic [7:0]  CH_ZERO      = 8'h30;
    localparam logic [7:0]  CH_UPPER_A   = 8'h41;
    localparam logic [7:0]  CH_LOWER_A   = 8'h61;

    typedef struct packed {
        logic [7:0]       data;
        logic             is_byte;
        logic             done;
        jsu_pkg::t_status status;
        logic             last;
    } t_decoded;

    typedef struct packed {
        logic [7:0]       b;
        logic             fin;
        logic             typed;
        jsu_pkg::t_status st;
    } t_row;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_in_valid    = 1'b0;
    logic [7:0] i_in_byte     = 8'h00;
    logic       i_final_byte  = 1'b0;
    logic       i_out_ready   = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_byte_valid;
    logic       o_token_done;
    logic [3:0] o_status;
    logic       o_last_of_run;

    jsu_pkg::t_phase dec_phase  = jsu_pkg::PH_IDLE;
    logic [15:0]     hex_word   = 16'h0000;
    logic [2:0]      hex_digits = 3'd0;
    logic            hex_bad    = 1'b0;
    logic [9:0]      high_bits  = 10'd0;

    t_decoded    step_out[$];
    t_decoded    decoded_q[$];
    logic [7:0]  tok_bytes[$];
    logic        tok_fin;

    bit          steady       = 1'b0;
    int          errors       = 0;
    int          items_sent   = 0;
    int          live_items   = 0;
    int          results_seen = 0;
    int          tokens_ended = 0;
    int          st_hits[16];

    t_row dir_rows [36] = '{
        '{8'h00,              1'b0, 1'b1, jsu_pkg::ST_NOQUOTE},
        '{jsu_pkg::CH_SPACE,  1'b1, 1'b1, jsu_pkg::ST_NOQUOTE},
        '{jsu_pkg::CH_TAB,    1'b0, 1'b0, jsu_pkg::ST_OK},
        '{jsu_pkg::CH_QUOTE,  1'b0, 1'b0, jsu_pkg::ST_OK},
        '{8'hFF,              1'b0, 1'b0, jsu_pkg::ST_OK},
        '{jsu_pkg::CH_BSLASH, 1'b0, 1'b0, jsu_pkg::ST_OK},
        '{jsu_pkg::CH_LOW_U,  1'b0, 1'b0, jsu_pkg::ST_OK},
        '{8'h44,              1'b0, 1'b0, jsu_pkg::ST_OK},
        '{8'h38,              1'b0, 1'b0, jsu_pkg::ST_OK},
        '{8'h33,              1'b0, 1'b0, jsu_pkg::ST_OK},
        '{8'h44,              1'b0, 1'b0, jsu_pkg::ST_OK},
        '{jsu_pkg::CH_BSLASH, 1'b0, 1'b0, jsu_pkg::ST_OK},
        '{jsu_pkg::CH_LOW_U,  1'b0, 1'b0, jsu_pkg::ST_OK},
        '{8'h44,              1'b0, 1'b0, jsu_pkg::ST_OK},
        '{8'h45,              1'b0, 1'b0, jsu_pkg::ST_OK},
        '{8'h30,              1'b0, 1'b0, jsu_pkg::ST_OK},
        '{8'h30,              1'b0, 1'b0, jsu_pkg::ST_OK},
        '{jsu_pkg::CH_QUOTE,  1'b1, 1'b1, jsu_pkg::ST_OK},
        '{jsu_pkg::CH_QUOTE,  1'b0, 1'b0, jsu_pkg::ST_OK},
        '{8'h1F,              1'b0, 1'b1, jsu_pkg::ST_CTRL},
        '{jsu_pkg::CH_QUOTE,  1'b1, 1'b1, jsu_pkg::ST_UNTERM},
        '{jsu_pkg::CH_QUOTE,  1'b0, 1'b0, jsu_pkg::ST_OK},
        '{jsu_pkg::CH_BSLASH, 1'b0, 1'b0, jsu_pkg::ST_OK},
        '{8'h71,              1'b0, 1'b1, jsu_pkg::ST_BADESC},
        '{jsu_pkg::CH_QUOTE,  1'b0, 1'b0, jsu_pkg::ST_OK},
        '{jsu_pkg::CH_BSLASH, 1'b0, 1'b0, jsu_pkg::ST_OK},
        '{jsu_pkg::CH_LOW_U,  1'b0, 1'b0, jsu_pkg::ST_OK},
        '{8'h30,              1'b0, 1'b0, jsu_pkg::ST_OK},
        '{8'h30,              1'b0, 1'b0, jsu_pkg::ST_OK},
        '{8'h30,              1'b0, 1'b0, jsu_pkg::ST_OK},
        '{8'h30,              1'b0, 1'b0, jsu_pkg::ST_OK},
        '{jsu_pkg::CH_BSLASH, 1'b1, 1'b1, jsu_pkg::ST_UNTERM},
        '{jsu_pkg::CH_QUOTE,  1'b0, 1'b0, jsu_pkg::ST_OK},
        '{jsu_pkg::CH_BSLASH, 1'b0, 1'b0, jsu_pkg::ST_OK},
        '{jsu_pkg::CH_LOW_U,  1'b0, 1'b0, jsu_pkg::ST_OK},
        '{8'h31,              1'b1, 1'b1, jsu_pkg::ST_TRUNC}
    };

    json_string_unescape_utf8 i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_byte     (i_in_byte),
        .i_final_byte  (i_final_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_token_done  (o_token_done),
        .o_status      (o_status),
        .o_last_of_run (o_last_of_run)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [4:0] nibble_of(input logic [7:0] b);
        if (b >= CH_ZERO && b <= CH_ZERO + 8'd9) return {1'b0, 4'(b - CH_ZERO)};
        if (b >= CH_LOWER_A && b <= CH_LOWER_A + 8'd5) return {1'b0, 4'(b - CH_LOWER_A + 8'd10)};
        if (b >= CH_UPPER_A && b <= CH_UPPER_A + 8'd5) return {1'b0, 4'(b - CH_UPPER_A + 8'd10)};
        return 5'h10;
    endfunction

    task automatic add_out(input logic [7:0] data, input logic is_byte, input logic done,
                           input jsu_pkg::t_status st);
        step_out.insert(step_out.size(), t_decoded'{data, is_byte, done, st, 1'b0});
    endtask

    task automatic clear_decoder();
        dec_phase  = jsu_pkg::PH_IDLE;
        hex_word   = 16'h0000;
        hex_digits = 3'd0;
        hex_bad    = 1'b0;
        high_bits  = 10'd0;
    endtask

    task automatic end_token(input jsu_pkg::t_status st);
        add_out(8'h00, 1'b0, 1'b1, st);
        clear_decoder();
    endtask

    task automatic emit_code_point(input logic [20:0] cp);
        if (cp < 21'h80) begin
            add_out(cp[7:0], 1'b1, 1'b0, jsu_pkg::ST_OK);
        end else if (cp < 21'h800) begin
            add_out({3'b110, cp[10:6]}, 1'b1, 1'b0, jsu_pkg::ST_OK);
            add_out({2'b10, cp[5:0]}, 1'b1, 1'b0, jsu_pkg::ST_OK);
        end else if (cp < 21'h10000) begin
            add_out({4'b1110, cp[15:12]}, 1'b1, 1'b0, jsu_pkg::ST_OK);
            add_out({2'b10, cp[11:6]}, 1'b1, 1'b0, jsu_pkg::ST_OK);
            add_out({2'b10, cp[5:0]}, 1'b1, 1'b0, jsu_pkg::ST_OK);
        end else begin
            add_out({5'b11110, cp[20:18]}, 1'b1, 1'b0, jsu_pkg::ST_OK);
            add_out({2'b10, cp[17:12]}, 1'b1, 1'b0, jsu_pkg::ST_OK);
            add_out({2'b10, cp[11:6]}, 1'b1, 1'b0, jsu_pkg::ST_OK);
            add_out({2'b10, cp[5:0]}, 1'b1, 1'b0, jsu_pkg::ST_OK);
        end
    endtask

    task automatic start_hex(input jsu_pkg::t_phase next);
        dec_phase  = next;
        hex_word   = 16'h0000;
        hex_digits = 3'd0;
        hex_bad    = 1'b0;
    endtask

    task automatic unescape_byte(input logic [7:0] b, input logic fin);
        logic [4:0]  d;
        logic [7:0]  v;
        logic        is_esc;
        logic [20:0] cp;
        step_out.delete();
        case (dec_phase)
            jsu_pkg::PH_IDLE: begin
                if (b == jsu_pkg::CH_SPACE || b == jsu_pkg::CH_TAB ||
                    b == jsu_pkg::CH_LF || b == jsu_pkg::CH_CR) begin
                    if (fin) end_token(jsu_pkg::ST_NOQUOTE);
                end else if (b == jsu_pkg::CH_QUOTE) begin
                    clear_decoder();
                    dec_phase = jsu_pkg::PH_STR;
                    if (fin) end_token(jsu_pkg::ST_UNTERM);
                end else begin
                    end_token(jsu_pkg::ST_NOQUOTE);
                end
            end
            jsu_pkg::PH_STR: begin
                if (b == jsu_pkg::CH_QUOTE) begin
                    end_token(jsu_pkg::ST_OK);
                end else if (b == jsu_pkg::CH_BSLASH) begin
                    dec_phase = jsu_pkg::PH_ESC;
                    if (fin) end_token(jsu_pkg::ST_UNTERM);
                end else if (b < jsu_pkg::CH_SPACE) begin
                    end_token(jsu_pkg::ST_CTRL);
                end else begin
                    add_out(b, 1'b1, 1'b0, jsu_pkg::ST_OK);
                    if (fin) end_token(jsu_pkg::ST_UNTERM);
                end
            end
            jsu_pkg::PH_ESC: begin
                is_esc = 1'b1;
                v = 8'h00;
                case (b)
                    jsu_pkg::CH_QUOTE:  v = jsu_pkg::CH_QUOTE;
                    jsu_pkg::CH_BSLASH: v = jsu_pkg::CH_BSLASH;
                    jsu_pkg::CH_SLASH:  v = jsu_pkg::CH_SLASH;
                    jsu_pkg::CH_LOW_B:  v = jsu_pkg::CH_BS;
                    jsu_pkg::CH_LOW_F:  v = jsu_pkg::CH_FF;
                    jsu_pkg::CH_LOW_N:  v = jsu_pkg::CH_LF;
                    jsu_pkg::CH_LOW_R:  v = jsu_pkg::CH_CR;
                    jsu_pkg::CH_LOW_T:  v = jsu_pkg::CH_TAB;
                    default:            is_esc = 1'b0;
                endcase
                if (is_esc) begin
                    add_out(v, 1'b1, 1'b0, jsu_pkg::ST_OK);
                    dec_phase = jsu_pkg::PH_STR;
                    if (fin) end_token(jsu_pkg::ST_UNTERM);
                end else if (b == jsu_pkg::CH_LOW_U) begin
                    start_hex(jsu_pkg::PH_HEX1);
                    if (fin) end_token(jsu_pkg::ST_TRUNC);
                end else begin
                    end_token(jsu_pkg::ST_BADESC);
                end
            end
            jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
                d = nibble_of(b);
                hex_word = {hex_word[11:0], d[3:0]};
                if (d[4]) hex_bad = 1'b1;
                hex_digits = hex_digits + 3'd1;
                if (hex_digits < 3'd4) begin
                    if (fin) end_token(jsu_pkg::ST_TRUNC);
                end else if (hex_bad) begin
                    end_token(jsu_pkg::ST_NONHEX);
                end else if (dec_phase == jsu_pkg::PH_HEX1) begin
                    if (hex_word >= 16'hD800 && hex_word <= 16'hDBFF) begin
                        high_bits = hex_word[9:0];
                        dec_phase = jsu_pkg::PH_WANT_BS;
                        if (fin) end_token(jsu_pkg::ST_LONEHIGH);
                    end else if (hex_word >= 16'hDC00 && hex_word <= 16'hDFFF) begin
                        end_token(jsu_pkg::ST_LONELOW);
                    end else begin
                        emit_code_point({5'd0, hex_word});
                        dec_phase = jsu_pkg::PH_STR;
                        if (fin) end_token(jsu_pkg::ST_UNTERM);
                    end
                end else begin
                    if (hex_word < 16'hDC00 || hex_word > 16'hDFFF) begin
                        end_token(jsu_pkg::ST_BADLOW);
                    end else begin
                        cp = 21'h10000 + {1'b0, high_bits, 10'b0} + {11'd0, hex_word[9:0]};
                        emit_code_point(cp);
                        dec_phase = jsu_pkg::PH_STR;
                        if (fin) end_token(jsu_pkg::ST_UNTERM);
                    end
                end
            end
            jsu_pkg::PH_WANT_BS: begin
                if (b != jsu_pkg::CH_BSLASH || fin) begin
                    end_token(jsu_pkg::ST_LONEHIGH);
                end else begin
                    dec_phase = jsu_pkg::PH_WANT_U;
                end
            end
            jsu_pkg::PH_WANT_U: begin
                if (b != jsu_pkg::CH_LOW_U) begin
                    end_token(jsu_pkg::ST_LONEHIGH);
                end else begin
                    start_hex(jsu_pkg::PH_HEX2);
                    if (fin) end_token(jsu_pkg::ST_TRUNC);
                end
            end
            default: clear_decoder();
        endcase
        if (step_out.size() > 0) begin
            step_out[step_out.size() - 1].last = 1'b1;
        end
    endtask

    task automatic send_item(input logic [7:0] b, input logic fin, input logic typed,
                             input jsu_pkg::t_status typed_st);
        int gap;
        logic blank;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_in_byte    <= b;
        i_final_byte <= fin;
        do @(posedge i_clk); while (!o_in_ready);
        blank = (b == jsu_pkg::CH_SPACE || b == jsu_pkg::CH_TAB ||
                 b == jsu_pkg::CH_LF || b == jsu_pkg::CH_CR);
        if (!(dec_phase == jsu_pkg::PH_IDLE && blank && !fin)) live_items++;
        items_sent++;
        unescape_byte(b, fin);
        if (typed) begin
            step_out.delete();
            step_out.insert(0, t_decoded'{8'h00, 1'b0, 1'b1, typed_st, 1'b1});
        end
        foreach (step_out[k]) decoded_q.insert(decoded_q.size(), step_out[k]);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (decoded_q.size() != 0);
    endtask

    task automatic add_tok(input logic [7:0] c);
        tok_bytes.insert(tok_bytes.size(), c);
    endtask

    task automatic push_hex(input logic [15:0] v);
        logic [3:0] n;
        for (int k = 3; k >= 0; k--) begin
            n = v[k*4 +: 4];
            if (n < 4'd10) add_tok(CH_ZERO + 8'(n));
            else if ($urandom_range(0, 1) != 0) add_tok(CH_UPPER_A + 8'(n) - 8'd10);
            else add_tok(CH_LOWER_A + 8'(n) - 8'd10);
        end
    endtask

    task automatic push_u_escape(input logic [15:0] v);
        add_tok(jsu_pkg::CH_BSLASH);
        add_tok(jsu_pkg::CH_LOW_U);
        push_hex(v);
    endtask

    task automatic make_token();
        int          r;
        int          nseg;
        int          pos;
        logic [7:0]  c;
        logic [15:0] w;
        logic [7:0]  blanks [4];
        logic [7:0]  escs [8];
        blanks = '{jsu_pkg::CH_SPACE, jsu_pkg::CH_TAB, jsu_pkg::CH_LF, jsu_pkg::CH_CR};
        escs   = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH,
                   jsu_pkg::CH_LOW_B, jsu_pkg::CH_LOW_F, jsu_pkg::CH_LOW_N,
                   jsu_pkg::CH_LOW_R, jsu_pkg::CH_LOW_T};
        tok_bytes.delete();
        tok_fin = 1'b0;
        if ($urandom_range(0, 99) < 5) begin
            repeat ($urandom_range(1, 4)) add_tok(8'($urandom_range(0, 255)));
            tok_fin = ($urandom_range(0, 3) == 0);
            return;
        end
        repeat ($urandom_range(0, 2)) add_tok(blanks[$urandom_range(0, 3)]);
        add_tok(jsu_pkg::CH_QUOTE);
        nseg = $urandom_range(0, 8);
        repeat (nseg) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                c = 8'($urandom_range(32, 255));
                if (c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BSLASH) c = CH_LOWER_A;
                add_tok(c);
            end else if (r < 55) begin
                add_tok(jsu_pkg::CH_BSLASH);
                add_tok(escs[$urandom_range(0, 7)]);
            end else if (r < 75) begin
                case ($urandom_range(0, 2))
                    0:       w = 16'($urandom_range(0, 'h7F));
                    1:       w = 16'($urandom_range('h80, 'h7FF));
                    default: w = 16'($urandom_range('h800, 'hFFFF));
                endcase
                if (w >= 16'hD800 && w <= 16'hDFFF) w = w ^ 16'h4000;
                push_u_escape(w);
            end else if (r < 87) begin
                push_u_escape(16'hD800 + 16'($urandom_range(0, 'h3FF)));
                push_u_escape(16'hDC00 + 16'($urandom_range(0, 'h3FF)));
            end else if (r < 93) begin
                push_u_escape(16'hDC00 + 16'($urandom_range(0, 'h3FF)));
            end else if (r < 97) begin
                push_u_escape(16'hD800 + 16'($urandom_range(0, 'h3FF)));
                push_u_escape(16'($urandom_range(0, 'hFFFF)));
            end else begin
                push_u_escape(16'hD800 + 16'($urandom_range(0, 'h3FF)));
                add_tok(CH_LOWER_A);
            end
        end
        add_tok(jsu_pkg::CH_QUOTE);
        if ($urandom_range(0, 99) < 12) begin
            pos = $urandom_range(0, tok_bytes.size() - 1);
            tok_bytes[pos] = 8'($urandom_range(0, 255));
        end
        r = $urandom_range(0, 99);
        if (r < 12) begin
            pos = $urandom_range(0, tok_bytes.size() - 1);
            while (tok_bytes.size() > pos + 1) void'(tok_bytes.pop_back());
            tok_fin = 1'b1;
        end else if (r < 20) begin
            tok_fin = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        t_decoded want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (decoded_q.size() == 0) begin
                errors++;
                $error("unexpected result: out_byte %02h token_done %0b status %0d",
                       o_out_byte, o_token_done, o_status);
            end else begin
                want = decoded_q.pop_front();
                if (o_out_byte !== want.data) begin
                    errors++;
                    $error("out_byte: expected %02h, got %02h", want.data, o_out_byte);
                end
                if (o_byte_valid !== want.is_byte) begin
                    errors++;
                    $error("byte_valid: expected %0b, got %0b", want.is_byte, o_byte_valid);
                end
                if (o_token_done !== want.done) begin
                    errors++;
                    $error("token_done: expected %0b, got %0b", want.done, o_token_done);
                end
                if (o_status !== want.status) begin
                    errors++;
                    $error("status: expected %0d, got %0d", want.status, o_status);
                end
                if (o_last_of_run !== want.last) begin
                    errors++;
                    $error("last_of_run: expected %0b, got %0b", want.last, o_last_of_run);
                end
                if (want.done) begin
                    tokens_ended++;
                    st_hits[want.status]++;
                end
            end
        end
    end

    initial begin
        int hold;
        int gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            hold = $urandom_range(1, 16);
            i_out_ready <= 1'b1;
            repeat (hold) @(posedge i_clk);
            gap = steady ? 0 : pick_gap();
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int    random_start;
        bit    paused;
        string hit_list;
        paused = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            send_item(dir_rows[k].b, dir_rows[k].fin, dir_rows[k].typed, dir_rows[k].st);
        end
        drain_results();

        random_start = live_items;
        while (live_items - random_start < RANDOM_ITEMS) begin
            steady = (live_items - random_start >= 150) && (live_items - random_start < 230);
            if (!paused && live_items - random_start >= 260) begin
                paused = 1'b1;
                drain_results();
            end
            make_token();
            foreach (tok_bytes[k]) begin
                send_item(tok_bytes[k], (k == tok_bytes.size() - 1) && tok_fin, 1'b0,
                          jsu_pkg::ST_OK);
            end
        end
        steady = 1'b0;

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        hit_list = "";
        for (int s = 0; s < 10; s++) hit_list = {hit_list, $sformatf(" %0d:%0d", s, st_hits[s])};
        $display("Fed %0d bytes, checked %0d output items across %0d finished tokens",
                 items_sent, results_seen, tokens_ended);
        $display("Token endings by status code:%s", hit_list);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
